// ===== hw/rtl/xbe_pkg.sv =====
// Shared types, constants and the word mix function for the block encryptor.
// Used by xbe_cell and xtea_block_encrypt; depends on nothing else.
`timescale 1ns / 1ps

package xbe_pkg;

  localparam int WORD_W      = 32;
  localparam int ROUND_W     = 8;
  localparam int KEY_WORDS   = 4;
  localparam int KEY_SEL_W   = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int MIX_LSHIFT  = 4;
  localparam int MIX_RSHIFT  = 5;
  localparam int KEY_HI_LSB  = 11;

  // Default number of round cells in the ring.
  localparam int CELL_COUNT = 4;

  // Register reset values.
  localparam logic [WORD_W-1:0]  KEY0_RESET     = 32'd5;
  localparam logic [WORD_W-1:0]  KEY1_RESET     = 32'd6;
  localparam logic [WORD_W-1:0]  KEY2_RESET     = 32'd7;
  localparam logic [WORD_W-1:0]  KEY3_RESET     = 32'd8;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET   = 8'd48;
  localparam logic [WORD_W-1:0]  CONSTANT_RESET = 32'h1234_5678;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_ROUNDS   = 3'd4,
    REG_CONSTANT = 3'd5
  } cfg_reg_e;

  // Key material seen by every cell.
  typedef struct packed {
    logic [KEY_WORDS-1:0][WORD_W-1:0] key;
    logic [WORD_W-1:0]                delta;
  } cipher_cfg_t;

  // One block in flight, handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  left;
    logic [WORD_W-1:0]  right;
    logic [WORD_W-1:0]  sum;
    logic [ROUND_W-1:0] rounds;
  } cell_word_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w);
    return ((w << MIX_LSHIFT) ^ (w >> MIX_RSHIFT)) + w;
  endfunction

endpackage

// ===== hw/rtl/xtea_block_encrypt.sv =====
// Top level of the XTEA-style block encryptor: configuration registers,
// ring of xbe_cell round cells and output register. Depends on xbe_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) takes one plaintext word pair
//   (plain_left, plain_right); output channel (out_valid / out_stall) gives
//   one ciphertext word pair (cipher_left, cipher_right) per input word.
//   Key words, round count and round constant are written through
//   cfg_write / cfg_index / cfg_data while the block is idle.
//   A block circulates through a ring of CELL_COUNT round cells, one round
//   per clock, until its round_count rounds are spent; the finished block
//   is then captured into the output register, which raises out_valid.
//   One block is in the ring at a time; in_stall is high while it is there,
//   so a new word is taken only once the previous block has left the ring.
//   The output register frees the ring as soon as a result is captured, so
//   the next word enters while the previous result waits to be taken.
//   If out_stall holds a result and the next block finishes, that block
//   keeps circulating unchanged in the ring until the register frees.
//   Reset (rst, synchronous) empties the ring and the output register and
//   loads the default key 5, 6, 7, 8, 48 rounds and constant 0x12345678.
module xtea_block_encrypt #(
  parameter int CELL_COUNT = xbe_pkg::CELL_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [xbe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xbe_pkg::WORD_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [xbe_pkg::WORD_W-1:0]      plain_left,
  input  logic [xbe_pkg::WORD_W-1:0]      plain_right,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [xbe_pkg::WORD_W-1:0]      cipher_left,
  output logic [xbe_pkg::WORD_W-1:0]      cipher_right
);

  xbe_pkg::cipher_cfg_t        cfg;
  logic [xbe_pkg::ROUND_W-1:0] round_count;

  xbe_pkg::cell_word_t         ring_in  [CELL_COUNT];
  xbe_pkg::cell_word_t         ring_out [CELL_COUNT];
  xbe_pkg::cell_word_t         load_word;
  logic [CELL_COUNT-1:0]       cell_valid;
  logic [CELL_COUNT-1:0]       cell_done;
  logic [xbe_pkg::WORD_W-1:0]  done_left;
  logic [xbe_pkg::WORD_W-1:0]  done_right;
  logic                        busy;
  logic                        in_accept;
  logic                        out_take;
  logic                        capture;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key[0]  <= xbe_pkg::KEY0_RESET;
      cfg.key[1]  <= xbe_pkg::KEY1_RESET;
      cfg.key[2]  <= xbe_pkg::KEY2_RESET;
      cfg.key[3]  <= xbe_pkg::KEY3_RESET;
      round_count <= xbe_pkg::ROUNDS_RESET;
      cfg.delta   <= xbe_pkg::CONSTANT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        xbe_pkg::REG_KEY0:     cfg.key[0]  <= cfg_data;
        xbe_pkg::REG_KEY1:     cfg.key[1]  <= cfg_data;
        xbe_pkg::REG_KEY2:     cfg.key[2]  <= cfg_data;
        xbe_pkg::REG_KEY3:     cfg.key[3]  <= cfg_data;
        xbe_pkg::REG_ROUNDS:   round_count <= cfg_data[xbe_pkg::ROUND_W-1:0];
        xbe_pkg::REG_CONSTANT: cfg.delta   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake control
  assign busy      = |cell_valid;
  assign in_stall  = busy;
  assign in_accept = in_valid & ~busy;
  assign out_take  = out_valid & ~out_stall;
  assign capture   = (|cell_done) & (~out_valid | out_take);

  // New block enters with a zero running sum
  always_comb begin
    load_word.valid  = 1'b1;
    load_word.left   = plain_left;
    load_word.right  = plain_right;
    load_word.sum    = '0;
    load_word.rounds = round_count;
  end

  // Ring of round cells; the last cell feeds the first
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign ring_in[k] = in_accept ? load_word : ring_out[CELL_COUNT-1];
    end else begin : g_link
      assign ring_in[k] = ring_out[k-1];
    end

    xbe_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .flush    (capture),
      .cfg      (cfg),
      .word_in  (ring_in[k]),
      .word_out (ring_out[k])
    );

    assign cell_valid[k] = ring_out[k].valid;
    assign cell_done[k]  = ring_out[k].valid & (ring_out[k].rounds == '0);
  end

  // Select the finished block; at most one cell holds a block
  always_comb begin
    done_left  = '0;
    done_right = '0;
    for (int k = 0; k < CELL_COUNT; k++) begin
      done_left  = done_left  | ({xbe_pkg::WORD_W{cell_done[k]}} & ring_out[k].left);
      done_right = done_right | ({xbe_pkg::WORD_W{cell_done[k]}} & ring_out[k].right);
    end
  end

  // Output register: load on capture, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cipher_left  <= done_left;
      cipher_right <= done_right;
    end
  end

`ifndef SYNTHESIS
  a_single_block: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid))
    else $error("more than one block in the round ring");

  a_capture_empties: assert property (@(posedge clk) disable iff (rst)
    capture |=> !busy)
    else $error("ring not empty after result capture");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> cell_valid[0])
    else $error("accepted word did not enter the first cell");

  a_capture_loads_out: assert property (@(posedge clk) disable iff (rst)
    capture |=> out_valid)
    else $error("captured result not presented at the output");
`endif

endmodule

// ===== hw/rtl/xbe_cell.sv =====
// One round cell of the encryptor ring: applies a single Feistel round and
// hands the block to its neighbor. Depends on xbe_pkg.
`timescale 1ns / 1ps

module xbe_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 flush,
  input  xbe_pkg::cipher_cfg_t cfg,
  input  xbe_pkg::cell_word_t  word_in,
  output xbe_pkg::cell_word_t  word_out
);

  logic [xbe_pkg::WORD_W-1:0]  left_next;
  logic [xbe_pkg::WORD_W-1:0]  right_next;
  logic [xbe_pkg::WORD_W-1:0]  sum_next;
  logic [xbe_pkg::WORD_W-1:0]  key_lo;
  logic [xbe_pkg::WORD_W-1:0]  key_hi;
  logic [xbe_pkg::ROUND_W-1:0] rounds_next;
  logic                        active;

  // Compute one round; pass the block unchanged once its rounds are spent
  always_comb begin
    active   = (word_in.rounds != '0);
    key_lo   = cfg.key[word_in.sum[xbe_pkg::KEY_SEL_W-1:0]];
    sum_next = word_in.sum + cfg.delta;
    key_hi   = cfg.key[sum_next[xbe_pkg::KEY_HI_LSB +: xbe_pkg::KEY_SEL_W]];
    left_next  = word_in.left +
                 (xbe_pkg::mix_word(word_in.right) ^ (word_in.sum + key_lo));
    right_next = word_in.right +
                 (xbe_pkg::mix_word(left_next) ^ (sum_next + key_hi));
    rounds_next = word_in.rounds - 1'b1;
    if (!active) begin
      left_next   = word_in.left;
      right_next  = word_in.right;
      sum_next    = word_in.sum;
      rounds_next = word_in.rounds;
    end
  end

  // Advance the payload every cycle; clear the valid flag under reset and
  // drop it when the block leaves the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else begin
      word_out.valid <= word_in.valid & ~flush;
    end
    word_out.left   <= left_next;
    word_out.right  <= right_next;
    word_out.sum    <= sum_next;
    word_out.rounds <= rounds_next;
  end

endmodule
